@@ hdl/csbr_pkg.sv @@
package csbr_pkg;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 3;
    localparam int SLOT_BITS   = 4;
    localparam int KEY_PORT    = 32;
    localparam int CAP_BITS    = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_BITS-1:0] OP_GET  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_PUT  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TICK = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_PRESENT  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_FREE     = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EVICT    = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NOVICTIM = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_TICK     = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_SWEEP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic decide;
        logic sweep_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_sweep;
        logic victim;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/csbr_ctrl.sv @@
module csbr_ctrl
    import csbr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = i_stat.need_sweep ? S_SWEEP : S_OUT;
            end
            S_SWEEP: begin
                if (i_stat.victim) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                // The input stays stalled while reset is held.
                o_in_stall    = !i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
            end
            S_OUT: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/csbr_dp.sv @@
module csbr_dp
    import csbr_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32,
    parameter int MAX_USE  = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic [OP_BITS-1:0]     i_operation,
    input  logic [KEY_PORT-1:0]    i_request_key,
    input  logic                   i_cfg_valid,
    input  logic [CAP_BITS-1:0]    i_cfg_data,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [SLOT_BITS-1:0]   o_slot,
    output logic [KEY_PORT-1:0]    o_evicted_key
);

    localparam int KW   = (KEY_BITS < KEY_PORT) ? KEY_BITS : KEY_PORT;
    localparam int SW   = $clog2(SLOTS);
    localparam int FW   = $clog2(SLOTS + 1);
    localparam int CW   = $clog2(MAX_USE + 1);
    localparam int CAPW = (FW > CAP_BITS) ? FW : CAP_BITS;
    localparam logic [CW-1:0]   USE_MAX   = CW'(MAX_USE);
    localparam logic [CW-1:0]   USE_ONE   = CW'(1);
    localparam logic [CAPW-1:0] SLOTS_CAP = CAPW'(SLOTS);

    logic [OP_BITS-1:0]  r_op;
    logic [KW-1:0]       r_key;
    logic [SLOTS-1:0]    r_match;
    logic [KW-1:0]       r_keys [SLOTS];
    logic [CW-1:0]       r_counts [SLOTS];
    logic [CW-1:0]       n_counts [SLOTS];
    logic [SLOTS-1:0]    r_pins;
    logic [SLOTS-1:0]    n_pins;
    logic [FW-1:0]       r_filled;
    logic [FW-1:0]       n_filled;
    logic [SW-1:0]       r_hand;
    logic [SW-1:0]       n_hand;
    logic [CAP_BITS-1:0] r_capacity;

    logic [STATUS_BITS-1:0] r_pend_status;
    logic [STATUS_BITS-1:0] n_pend_status;
    logic [SW-1:0]          r_pend_slot;
    logic [SW-1:0]          n_pend_slot;
    logic [KEY_PORT-1:0]    r_pend_ekey;
    logic [KEY_PORT-1:0]    n_pend_ekey;

    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [SW-1:0]          r_out_slot;
    logic [KEY_PORT-1:0]    r_out_ekey;

    logic          key_we;
    logic [SW-1:0] key_idx;
    logic          hit;
    logic [SW-1:0] hit_idx;
    logic          any_free;
    logic          full;
    logic          at_victim;
    logic [FW-1:0] hand_next;

    always_comb begin
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = SW'(i);
            end
        end
        hit = |r_match;
    end

    always_comb begin
        any_free = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if ((FW'(i) < r_filled) && !r_pins[i]) begin
                any_free = 1'b1;
            end
        end
    end

    // The effective capacity is the smaller of the register and the table size.
    assign full = (CAPW'(r_filled) >= CAPW'(r_capacity)) || (CAPW'(r_filled) >= SLOTS_CAP);

    assign at_victim = (r_counts[r_hand] == '0) && !r_pins[r_hand];
    assign hand_next = (FW'(r_hand) + FW'(1) >= r_filled) ? '0 : FW'(r_hand) + FW'(1);

    assign o_stat.need_sweep = (r_op == OP_PUT) && !hit && full && any_free;
    assign o_stat.victim     = at_victim;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        logic [KW+KEY_PORT-1:0] ek_wide;
        ek_wide       = {{KEY_PORT{1'b0}}, r_keys[r_hand]};
        n_counts      = r_counts;
        n_pins        = r_pins;
        n_filled      = r_filled;
        n_hand        = r_hand;
        n_pend_status = r_pend_status;
        n_pend_slot   = r_pend_slot;
        n_pend_ekey   = r_pend_ekey;
        key_we        = 1'b0;
        key_idx       = r_hand;

        if (i_cmd.decide) begin
            n_pend_status = ST_MISS;
            n_pend_slot   = '0;
            n_pend_ekey   = '0;
            case (r_op)
                OP_GET, OP_PUT: begin
                    if (hit) begin
                        if (r_counts[hit_idx] < USE_MAX) begin
                            n_counts[hit_idx] = r_counts[hit_idx] + USE_ONE;
                        end
                        n_pins[hit_idx] = 1'b1;
                        n_pend_status   = (r_op == OP_GET) ? ST_HIT : ST_PRESENT;
                        n_pend_slot     = hit_idx;
                    end else if (r_op == OP_PUT) begin
                        if (!full) begin
                            key_we            = 1'b1;
                            key_idx           = r_filled[SW-1:0];
                            n_counts[key_idx] = USE_ONE;
                            n_pins[key_idx]   = 1'b1;
                            n_filled          = r_filled + FW'(1);
                            n_pend_status     = ST_FREE;
                            n_pend_slot       = key_idx;
                        end else if (!any_free) begin
                            n_pend_status = ST_NOVICTIM;
                        end else if (FW'(r_hand) >= r_filled) begin
                            n_hand = '0;
                        end
                    end
                end
                OP_TICK: begin
                    n_pins = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (r_counts[i] != '0) begin
                            n_counts[i] = r_counts[i] - USE_ONE;
                        end
                    end
                    n_pend_status = ST_TICK;
                end
                default: begin
                    n_pend_status = ST_MISS;
                end
            endcase
        end

        // One slot under the hand per cycle: age it if its count is not zero, else
        // take it when it is unpinned; a pinned slot at zero is passed over.
        if (i_cmd.sweep_step) begin
            n_hand = hand_next[SW-1:0];
            if (r_counts[r_hand] != '0) begin
                n_counts[r_hand] = r_counts[r_hand] - USE_ONE;
            end else if (!r_pins[r_hand]) begin
                key_we           = 1'b1;
                n_counts[r_hand] = USE_ONE;
                n_pins[r_hand]   = 1'b1;
                n_pend_status    = ST_EVICT;
                n_pend_slot      = r_hand;
                n_pend_ekey      = ek_wide[KEY_PORT-1:0];
            end
        end
    end

    always_comb begin
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins      <= '0;
            r_filled    <= '0;
            r_hand      <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_pins      <= n_pins;
            r_filled    <= n_filled;
            r_hand      <= n_hand;
            r_counts    <= n_counts;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_key <= i_request_key[KW-1:0];
        end
        if (i_cmd.match) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_match[i] <= (r_keys[i] == r_key) && (FW'(i) < r_filled);
            end
        end
        if (key_we) begin
            r_keys[key_idx] <= r_key;
        end
        r_pend_status <= n_pend_status;
        r_pend_slot   <= n_pend_slot;
        r_pend_ekey   <= n_pend_ekey;
        if (i_cmd.emit) begin
            r_out_status <= r_pend_status;
            r_out_slot   <= r_pend_slot;
            r_out_ekey   <= r_pend_ekey;
        end
    end

    logic [SW+SLOT_BITS-1:0] slot_wide;
    assign slot_wide = {{SLOT_BITS{1'b0}}, r_out_slot};

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = slot_wide[SLOT_BITS-1:0];
    assign o_evicted_key = r_out_ekey;

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FW'(SLOTS))
        else $error("filled slot count exceeds table size");

    a_hand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_filled == '0) || (FW'(r_hand) < r_filled))
        else $error("sweep hand points past the filled slots");

    a_victim_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep_step && at_victim) |=> (r_pend_status == ST_EVICT))
        else $error("sweep found a victim without an evicted result");

    a_sweep_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sweep_step |-> any_free)
        else $error("sweep running with every filled slot pinned");

endmodule

@@ hdl/clock_sweep_buffer_replacement.sv @@
// A result word is valid after key compare, priority select and update, and output load
// when no sweep is needed; the load waits while a stalled result holds the output.
// A replacing put runs the clock hand over one slot per cycle before the output load;
// the next word can be taken in the cycle after the result loads.
// No new word is taken before the last result loads. Reset is synchronous, active
// low: counts, pins, fill count and hand clear and capacity returns to 16.
module clock_sweep_buffer_replacement
    import csbr_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32,
    parameter int MAX_USE  = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OP_BITS-1:0]     i_operation,
    input  logic [KEY_PORT-1:0]    i_request_key,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [SLOT_BITS-1:0]   o_slot,
    output logic [KEY_PORT-1:0]    o_evicted_key,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_BITS-1:0]    i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = i_rst_n;

    csbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    csbr_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS),
        .MAX_USE  (MAX_USE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_request_key (i_request_key),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_evicted_key (o_evicted_key)
    );

endmodule
